>>> rtl/core/virtqueue_tx_ring_manager_top_assert.svh
// Assertion macros for the transmit ring manager.
// Taken in by the top level; relies on clk and rst_n being in scope.
`ifndef VIRTQUEUE_TX_RING_MANAGER_TOP_ASSERT_SVH
`define VIRTQUEUE_TX_RING_MANAGER_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define VTRM_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define VTRM_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/core/vtrm_pkg.sv
// Shared types, codes and constants of the transmit ring manager.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vtrm_pkg;

  localparam int unsigned RING_SIZE_DEF = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_PUSH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_POST   = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_RETIRE = 2'd2,
    KIND_USED   = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [47:0] buf_addr;
    logic [15:0] buf_len;
    logic [15:0] used_id;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  slot;
    logic [5:0]  desc_index;
    logic [47:0] out_addr;
    logic [15:0] out_len;
    logic        pending;
    logic        last;
  } out_item_t;

  // Classified request as held in the queue between front and back.
  typedef struct packed {
    cmd_t        cmd;
    logic [47:0] addr;
    logic [15:0] len;
    logic [5:0]  id;
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PUSH,
    BK_SEND,
    BK_SCAN_RD,
    BK_SCAN_CHK,
    BK_FIRST,
    BK_RET_RD,
    BK_RET_SL,
    BK_RET_EM
  } bk_state_t;

  // Data descriptor of a slot: the odd one of its pair.
  function automatic logic [5:0] desc_of(input logic [4:0] slot);
    return {slot, 1'b1};
  endfunction

endpackage

>>> rtl/core/virtqueue_tx_ring_manager_top.sv
// Transmit ring manager, driver side of a split virtqueue with paired descriptors.
// A front queue of two requests feeds a back end that owns all ring state. For a send
// request the back end first walks the used ring to count the retirable entries
// (each through the single registered read port of the used-ring memory), then
// emits the send result and one retire result per buffer, each needing a used-ring
// read and a slot-memory read in turn. The front keeps accepting requests while the
// back end works, until its queue is full.
// Depends on vtrm_pkg, vtrm_front, vtrm_back and the assertion macro header.
`timescale 1ns / 1ps

module virtqueue_tx_ring_manager_top #(
  parameter int unsigned RING_SIZE = vtrm_pkg::RING_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  vtrm_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output vtrm_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import vtrm_pkg::*;

  logic q_valid;
  op_t  q_op;
  logic q_pop;

  vtrm_front #(
    .RING_SIZE(RING_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop)
  );

  vtrm_back #(
    .RING_SIZE(RING_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`include "virtqueue_tx_ring_manager_top_assert.svh"

  // A used-entry record is always the only result of its request.
  `VTRM_ASSERT_SAME(a_used_is_last, out_valid && out_data.kind == KIND_USED, out_data.last, "used-entry result without last")

  // A non-final result is always followed by a retire result of the same request.
  `VTRM_ASSERT_NEXT(a_retire_follows, out_valid && !out_stall && !out_data.last, !out_valid || out_data.kind == KIND_RETIRE, "non-final result not followed by retire")

endmodule

>>> rtl/core/vtrm_front.sv
// Front end: accepts requests, masks the device id and queues them.
// Depends on vtrm_pkg.
`timescale 1ns / 1ps

module vtrm_front #(
  parameter int unsigned RING_SIZE = vtrm_pkg::RING_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  vtrm_pkg::in_item_t in_data,
  output logic               in_stall,
  output logic               q_valid,
  output vtrm_pkg::op_t      q_op,
  input  logic               q_pop
);
  import vtrm_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [5:0]  ID_MASK = 6'(RING_SIZE - 1);

  op_t             fifo_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            push;
  op_t             op_in;

  assign in_stall = (cnt_r == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_op     = fifo_r[rd_ptr_r];

  always_comb begin
    op_in.cmd  = in_data.cmd;
    op_in.addr = in_data.buf_addr;
    op_in.len  = in_data.buf_len;
    op_in.id   = in_data.used_id[5:0] & ID_MASK;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

>>> rtl/core/vtrm_back.sv
// Back end: ring state, used-ring and slot memories, retire walk and result register.
// Depends on vtrm_pkg.
`timescale 1ns / 1ps

module vtrm_back #(
  parameter int unsigned RING_SIZE = vtrm_pkg::RING_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  vtrm_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                out_valid,
  output vtrm_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import vtrm_pkg::*;

  localparam int unsigned NSLOT = (RING_SIZE + 1) / 2;
  localparam int unsigned QW    = $clog2(RING_SIZE);
  localparam int unsigned SW    = $clog2(NSLOT);
  localparam int unsigned CW    = $clog2(NSLOT + 1);
  localparam logic [QW-1:0] QMASK = QW'(RING_SIZE - 1);
  localparam logic [SW-1:0] SMASK = SW'((RING_SIZE - 1) >> 1);

  bk_state_t state_r, state_nxt;
  op_t       op_r;

  logic [15:0]      send_index_r;
  logic [15:0]      used_index_r;
  logic [15:0]      retire_index_r;
  logic [15:0]      scan_idx_r;
  logic [NSLOT-1:0] busy_r;
  logic [NSLOT-1:0] seen_r;
  logic [CW-1:0]    cnt_r;
  kind_t            first_kind_r;
  logic [SW-1:0]    first_slot_r;
  logic             pend_r;

  logic [QW-1:0]    used_ring [RING_SIZE];
  logic [47:0]      slot_addr [NSLOT];
  logic [15:0]      slot_len  [NSLOT];
  logic [QW-1:0]    rd_id_r;
  logic [47:0]      rd_addr_r;
  logic [15:0]      rd_len_r;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic          emit_ok;
  logic          emit;
  out_item_t     emit_item;
  logic          used_wr;
  logic          slot_wr;
  logic          take;
  logic          retire;
  logic          pend_calc;
  logic [QW-1:0] rd_addr;
  logic [QW-1:0] wr_addr;
  logic [SW-1:0] send_slot;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] push_slot;

  assign emit_ok   = !out_valid_r || !out_stall;
  assign send_slot = send_index_r[SW-1:0] & SMASK;
  assign rd_slot   = SW'(rd_id_r >> 1);
  assign push_slot = SW'(op_r.id[QW-1:0] >> 1);
  assign wr_addr   = used_index_r[QW-1:0] & QMASK;
  assign rd_addr   = (state_r == BK_SCAN_RD) ? (scan_idx_r[QW-1:0] & QMASK)
                                             : (retire_index_r[QW-1:0] & QMASK);
  assign take      = busy_r[rd_slot] && !seen_r[rd_slot];
  assign pend_calc = (retire_index_r + 16'(cnt_r)) != used_index_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_op.cmd == CMD_PUSH) ? BK_PUSH : BK_SEND;
        end
      end
      BK_PUSH:     if (emit_ok) state_nxt = BK_IDLE;
      BK_SEND:     state_nxt = BK_SCAN_RD;
      BK_SCAN_RD:  state_nxt = (scan_idx_r == used_index_r) ? BK_FIRST : BK_SCAN_CHK;
      BK_SCAN_CHK: state_nxt = take ? BK_SCAN_RD : BK_FIRST;
      BK_FIRST: begin
        if (emit_ok) begin
          state_nxt = (cnt_r == '0) ? BK_IDLE : BK_RET_RD;
        end
      end
      BK_RET_RD:   state_nxt = BK_RET_SL;
      BK_RET_SL:   state_nxt = BK_RET_EM;
      BK_RET_EM: begin
        if (emit_ok) begin
          state_nxt = (cnt_r == CW'(1)) ? BK_IDLE : BK_RET_RD;
        end
      end
      default:     state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    used_wr   = 1'b0;
    slot_wr   = 1'b0;
    retire    = 1'b0;
    emit_item = '0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_PUSH: begin
        emit               = emit_ok;
        used_wr            = emit_ok;
        emit_item.kind     = KIND_USED;
        emit_item.slot     = 5'(push_slot);
        emit_item.pending  = retire_index_r != (used_index_r + 16'd1);
        emit_item.last     = 1'b1;
      end
      BK_SEND: slot_wr = !busy_r[send_slot];
      BK_FIRST: begin
        emit               = emit_ok;
        emit_item.kind     = first_kind_r;
        emit_item.slot     = 5'(first_slot_r);
        emit_item.out_addr = op_r.addr;
        emit_item.out_len  = op_r.len;
        emit_item.pending  = pend_calc;
        emit_item.last     = (cnt_r == '0);
      end
      BK_RET_EM: begin
        emit               = emit_ok;
        retire             = emit_ok;
        emit_item.kind     = KIND_RETIRE;
        emit_item.slot     = 5'(rd_slot);
        emit_item.out_addr = rd_addr_r;
        emit_item.out_len  = rd_len_r;
        emit_item.pending  = pend_r;
        emit_item.last     = (cnt_r == CW'(1));
      end
      default: ;
    endcase
    emit_item.desc_index = desc_of(emit_item.slot);
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      send_index_r   <= '0;
      used_index_r   <= '0;
      retire_index_r <= '0;
      busy_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (used_wr) begin
        used_index_r <= used_index_r + 16'd1;
      end
      if (slot_wr) begin
        busy_r[send_slot] <= 1'b1;
        send_index_r      <= send_index_r + 16'd1;
      end
      if (retire) begin
        busy_r[rd_slot] <= 1'b0;
        retire_index_r  <= retire_index_r + 16'd1;
      end
    end
  end

  // Payload and walk bookkeeping; the walk counts retirable entries first so that
  // the pending flag is known before the first result of a send goes out.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
    if (emit) begin
      out_data_r <= emit_item;
    end
    if (state_r == BK_SEND) begin
      first_kind_r <= busy_r[send_slot] ? KIND_DROP : KIND_POST;
      first_slot_r <= send_slot;
      scan_idx_r   <= retire_index_r;
      seen_r       <= '0;
      cnt_r        <= '0;
    end
    if (state_r == BK_SCAN_CHK && take) begin
      seen_r[rd_slot] <= 1'b1;
      cnt_r           <= cnt_r + CW'(1);
      scan_idx_r      <= scan_idx_r + 16'd1;
    end
    if (state_r == BK_FIRST) begin
      pend_r <= pend_calc;
    end
    if (retire) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (used_wr) begin
      used_ring[wr_addr] <= op_r.id[QW-1:0];
    end
    rd_id_r <= used_ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      slot_addr[send_slot] <= op_r.addr;
      slot_len[send_slot]  <= op_r.len;
    end
    rd_addr_r <= slot_addr[rd_slot];
    rd_len_r  <= slot_len[rd_slot];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the transmit ring manager, with its own ring predictor.
// Depends on vtrm_pkg and virtqueue_tx_ring_manager_top; reads no files.
`timescale 1ns / 1ps

import vtrm_pkg::*;

class tx_ring_scoreboard;
  int unsigned qmask;
  int unsigned slotmask;
  logic [15:0] send_idx;
  logic [15:0] used_idx;
  logic [15:0] retire_idx;
  logic [5:0]  used_ids [64];
  bit          busy [32];
  logic [47:0] slot_addr [32];
  logic [15:0] slot_len [32];
  out_item_t   expected [$];
  int unsigned errors;

  function new(int unsigned ring_size);
    qmask = ring_size - 1;
    slotmask = qmask >> 1;
    send_idx = '0;
    used_idx = '0;
    retire_idx = '0;
    errors = 0;
    foreach (busy[i]) busy[i] = 1'b0;
  endfunction

  function out_item_t make_result(kind_t k, logic [4:0] s, logic [47:0] a, logic [15:0] l);
    out_item_t r;
    r.kind = k;
    r.slot = s;
    r.desc_index = {s, 1'b1};
    r.out_addr = a;
    r.out_len = l;
    r.pending = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out every result of one accepted request and returns the first of them.
  function out_item_t note_request(in_item_t req);
    out_item_t res [$];
    logic [5:0] id;
    logic [4:0] s;
    logic [4:0] t;
    if (req.cmd == CMD_PUSH) begin
      id = req.used_id[5:0] & qmask[5:0];
      used_ids[(used_idx & qmask) & 63] = id;
      used_idx = used_idx + 16'd1;
      res.push_back(make_result(KIND_USED, 5'((id >> 1) & 31), '0, '0));
    end else begin
      s = 5'((send_idx & slotmask) & 31);
      if (!busy[s]) begin
        busy[s] = 1'b1;
        slot_addr[s] = req.buf_addr;
        slot_len[s] = req.buf_len;
        send_idx = send_idx + 16'd1;
        res.push_back(make_result(KIND_POST, s, req.buf_addr, req.buf_len));
      end else begin
        res.push_back(make_result(KIND_DROP, s, req.buf_addr, req.buf_len));
      end
      // Retiring walks the used ring in order and halts at an entry naming an empty slot.
      while (retire_idx != used_idx && res.size() < 33) begin
        id = used_ids[(retire_idx & qmask) & 63];
        t = 5'(((id & qmask) >> 1) & 31);
        if (!busy[t]) break;
        busy[t] = 1'b0;
        res.push_back(make_result(KIND_RETIRE, t, slot_addr[t], slot_len[t]));
        retire_idx = retire_idx + 16'd1;
      end
    end
    foreach (res[i]) begin
      res[i].pending = (retire_idx != used_idx);
      res[i].last = (i == res.size() - 1);
      expected.push_back(res[i]);
    end
    return res[0];
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("ERROR: %s", msg);
  endtask

  task compare_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (expected.size() == 0) begin
      report_mismatch($sformatf("result kind %0d slot %0d arrived with none outstanding",
                                got.kind, got.slot));
      return;
    end
    want = expected.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("slot", got.slot, want.slot);
    compare_field("desc_index", got.desc_index, want.desc_index);
    compare_field("out_addr", got.out_addr, want.out_addr);
    compare_field("out_len", got.out_len, want.out_len);
    compare_field("pending", got.pending, want.pending);
    compare_field("last", got.last, want.last);
  endtask
endclass

module tb;
  localparam int unsigned RING = RING_SIZE_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall = 1'b0;

  tx_ring_scoreboard sb;
  out_item_t   head_result;
  logic [4:0]  posted_slots [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  virtqueue_tx_ring_manager_top #(.RING_SIZE(RING)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function logic [47:0] rand_addr();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[47:0];
  endfunction

  task automatic put_request(in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    head_result = sb.note_request(req);
  endtask

  task automatic do_send(logic [47:0] addr, logic [15:0] len);
    in_item_t req;
    req.cmd = CMD_SEND;
    req.buf_addr = addr;
    req.buf_len = len;
    req.used_id = 16'($urandom);
    put_request(req);
    if (head_result.kind == KIND_POST) posted_slots.push_back(head_result.slot);
  endtask

  task automatic do_push(logic [15:0] id);
    in_item_t req;
    req.cmd = CMD_PUSH;
    req.buf_addr = rand_addr();
    req.buf_len = 16'($urandom);
    req.used_id = id;
    put_request(req);
  endtask

  // The device completes the oldest posted buffer (with none posted, a send goes in);
  // the id carries noise above the ring mask and either descriptor of the pair.
  task automatic complete_oldest();
    logic [4:0] s;
    if (posted_slots.size() == 0) begin
      do_send(rand_addr(), 16'($urandom));
    end else begin
      s = posted_slots.pop_front();
      do_push({10'($urandom), s, 1'($urandom)});
    end
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45) do_send(rand_addr(), 16'($urandom));
      else if (r < 90) complete_oldest();
      else do_push(16'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned guard;
    sb = new(RING);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an entry naming an empty slot, posting and retiring in one send,
    // masked ids and the extremes of address and length.
    do_push(16'h0000);
    do_send(48'hFFFF_FFFF_FFFF, 16'hFFFF);
    do_send(48'h0, 16'h0);
    do_send(48'h5555_5555_5555, 16'hAAAA);
    do_push(16'hFFC3);
    do_push(16'h0004);
    do_push(16'h0006);
    do_send(48'h8000_0000_0001, 16'h8001);
    posted_slots.delete();
    drain();

    // Fill the ring until a packet is dropped, complete every buffer, then one send
    // retires them all.
    guard = 0;
    do begin
      do_send(rand_addr(), 16'($urandom));
      guard++;
    end while (head_result.kind != KIND_DROP && guard < 40);
    while (posted_slots.size() != 0) complete_oldest();
    do_send(rand_addr(), 16'($urandom));
    random_traffic(20);
    drain();

    idle_pct = 56;
    stall_pct = 0;
    random_traffic(60);
    drain();

    // More unretired entries than the ring holds, so the oldest are overwritten.
    idle_pct = 0;
    stall_pct = 56;
    repeat (68) do_push(16'($urandom));
    do_send(rand_addr(), 16'($urandom));
    posted_slots.delete();
    random_traffic(40);
    drain();

    idle_pct = 28;
    stall_pct = 28;
    random_traffic(60);
    drain();

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
